FILE: hw/rtl/lbps_pkg.sv
// Package for the LED/buzzer pattern sequencer: codes, widths and timing tables.
package lbps_pkg;

  localparam int unsigned LevelW = 7;
  localparam int unsigned FreqW  = 16;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned KindW  = 3;
  localparam int unsigned SigTW  = 7;
  localparam int unsigned ModeTW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] LvlFull = 7'd100;
  localparam logic [LevelW-1:0] LvlOff  = 7'd0;

  // opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // background modes
  localparam logic [ModeW-1:0] MODE_NORMAL = 3'd0;
  localparam logic [ModeW-1:0] MODE_FLYING = 3'd1;
  localparam logic [ModeW-1:0] MODE_PROC1  = 3'd2;
  localparam logic [ModeW-1:0] MODE_PROC2  = 3'd3;
  localparam logic [ModeW-1:0] MODE_MANUAL = 3'd4;

  // signal kinds
  localparam logic [KindW-1:0] SIG_START1   = 3'd0;
  localparam logic [KindW-1:0] SIG_START2   = 3'd1;
  localparam logic [KindW-1:0] SIG_CONTINUE = 3'd2;
  localparam logic [KindW-1:0] SIG_SUCCESS  = 3'd3;
  localparam logic [KindW-1:0] SIG_ERR1     = 3'd4;

  // config register indexes
  localparam logic [CfgIdxW-1:0] REG_LED_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAN_RED   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAN_GREEN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAN_BLUE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAN_BUZ   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAN_HZ    = 3'd5;

  // tone frequencies
  localparam logic [FreqW-1:0] HZ_800  = 16'd800;
  localparam logic [FreqW-1:0] HZ_900  = 16'd900;
  localparam logic [FreqW-1:0] HZ_1000 = 16'd1000;
  localparam logic [FreqW-1:0] HZ_1200 = 16'd1200;
  localparam logic [FreqW-1:0] HZ_1500 = 16'd1500;

  // last tick index of each signal; the tick after it ends the signal
  function automatic logic [SigTW-1:0] sig_len(input logic [KindW-1:0] id);
    logic [SigTW-1:0] len;
    unique case (id)
      SIG_START1:   len = 7'd30;
      SIG_START2:   len = 7'd45;
      SIG_CONTINUE: len = 7'd80;
      SIG_SUCCESS:  len = 7'd80;
      default:      len = 7'd100;
    endcase
    return len;
  endfunction

  function automatic logic [LevelW-1:0] sat100(input logic [LevelW-1:0] v);
    return (v > LvlFull) ? LvlFull : v;
  endfunction

  // floor(x / 10) for x below 1029, by reciprocal multiply
  function automatic logic [LevelW-1:0] div10(input logic [9:0] x);
    logic [17:0] prod;
    prod = {8'd0, x} * 18'd205;
    return prod[17:11];
  endfunction

endpackage

FILE: hw/rtl/led_buzzer_pattern_sequencer_top.sv
// LED/buzzer pattern sequencer: update of light and tone state per input word.
// An accepted input word loads input register s1; its result loads the state/result
// register when s1 advances. Throughput: one word per cycle while out_ready is high;
// a held, unread result stalls it. The per-word update is a single combinational pass.
// Reset (rst_n low, synchronous): pipeline empty, led_mode = processing1, all other
// config registers and sequencer state zero.
module led_buzzer_pattern_sequencer_top
  import lbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [KindW-1:0]    in_signal_kind,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LevelW-1:0]   out_red_level,
  output logic [LevelW-1:0]   out_green_level,
  output logic [LevelW-1:0]   out_blue_level,
  output logic                out_buzzer_active,
  output logic [FreqW-1:0]    out_buzzer_freq_hz,
  output logic                out_signal_playing,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // config registers
  logic [ModeW-1:0]  led_mode_r;
  logic [LevelW-1:0] man_red_r, man_green_r, man_blue_r;
  logic              man_buz_en_r;
  logic [FreqW-1:0]  man_hz_r;

  // input stage
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [KindW-1:0]  s1_kind_r;

  // sequencer state; the hold registers double as the result register
  logic              out_valid_r;
  logic              sig_on_r, sig_on_nxt;
  logic [KindW-1:0]  sig_id_r, sig_id_nxt;
  logic [SigTW-1:0]  sig_t_r, sig_t_nxt;
  logic [ModeTW-1:0] mode_t_r, mode_t_nxt;
  logic [LevelW-1:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic              buzz_r, buzz_nxt;
  logic [FreqW-1:0]  freq_r, freq_nxt;

  logic              adv;
  logic [ModeTW-1:0] bg_t;
  logic [9:0]        t3;
  logic [LevelW-1:0] fly_green, fly_blue;
  logic [ModeTW-1:0] p2_up, p2_dn;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_mode_r   <= MODE_PROC1;
      man_red_r    <= '0;
      man_green_r  <= '0;
      man_blue_r   <= '0;
      man_buz_en_r <= 1'b0;
      man_hz_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LED_MODE:  led_mode_r   <= cfg_data[ModeW-1:0];
        REG_MAN_RED:   man_red_r    <= cfg_data[LevelW-1:0];
        REG_MAN_GREEN: man_green_r  <= cfg_data[LevelW-1:0];
        REG_MAN_BLUE:  man_blue_r   <= cfg_data[LevelW-1:0];
        REG_MAN_BUZ:   man_buz_en_r <= cfg_data[0];
        REG_MAN_HZ:    man_hz_r     <= cfg_data[FreqW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_opcode;
      s1_kind_r <= in_signal_kind;
    end
  end

  // background period wrap
  always_comb begin
    bg_t = mode_t_r;
    unique case (led_mode_r)
      MODE_NORMAL: if (mode_t_r > 8'd200) bg_t = '0;
      MODE_FLYING: if (mode_t_r > 8'd140) bg_t = '0;
      MODE_PROC1, MODE_PROC2: if (mode_t_r > 8'd50) bg_t = '0;
      default: ;
    endcase
  end

  // flying ramp: green = 3t/10, blue = (300 - 3t)/10
  assign t3        = {2'b00, bg_t} + {1'b0, bg_t, 1'b0};
  assign fly_green = div10(t3);
  assign fly_blue  = div10(10'd300 - t3);

  // processing2 ramps, valid over t <= 50
  assign p2_up = {bg_t[5:0], 2'b00};
  assign p2_dn = {bg_t[5:0] - 6'd25, 2'b00};

  always_comb begin
    sig_on_nxt = sig_on_r;
    sig_id_nxt = sig_id_r;
    sig_t_nxt  = sig_t_r;
    mode_t_nxt = mode_t_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    buzz_nxt   = buzz_r;
    freq_nxt   = freq_r;

    if (s1_op_r == OP_START) begin
      if (s1_kind_r <= SIG_ERR1) begin
        sig_on_nxt = 1'b1;
        sig_id_nxt = s1_kind_r;
        sig_t_nxt  = '0;
      end
    end else if (sig_on_r) begin
      if (sig_t_r > sig_len(sig_id_r)) begin
        // closing tick: outputs untouched
        sig_on_nxt = 1'b0;
        sig_t_nxt  = '0;
      end else begin
        sig_t_nxt = sig_t_r + 7'd1;
        unique case (sig_id_r)
          SIG_START1: begin
            buzz_nxt = 1'b1;
            if (sig_t_r < 7'd15) begin
              freq_nxt = HZ_900;
              {red_nxt, green_nxt, blue_nxt} = {LvlOff, LvlOff, LvlFull};
            end else begin
              freq_nxt = HZ_1500;
              {red_nxt, green_nxt, blue_nxt} = {LvlOff, LvlFull, LvlOff};
            end
          end
          SIG_START2: begin
            buzz_nxt = 1'b1;
            if (sig_t_r < 7'd15) begin
              freq_nxt = HZ_800;
              {red_nxt, green_nxt, blue_nxt} = {LvlFull, LvlOff, LvlOff};
            end else if (sig_t_r < 7'd30) begin
              freq_nxt = HZ_1000;
              {red_nxt, green_nxt, blue_nxt} = {LvlOff, LvlFull, LvlOff};
            end else begin
              freq_nxt = HZ_1200;
              {red_nxt, green_nxt, blue_nxt} = {LvlOff, LvlOff, LvlFull};
            end
          end
          SIG_CONTINUE: begin
            freq_nxt = HZ_1500;
            red_nxt  = LvlOff;
            green_nxt = LvlOff;
            if (sig_t_r < 7'd20) begin
              blue_nxt = LvlFull;
              buzz_nxt = 1'b1;
            end else if (sig_t_r < 7'd40) begin
              blue_nxt = LvlOff;
              buzz_nxt = 1'b0;
            end else if (sig_t_r < 7'd60) begin
              blue_nxt = LvlFull;
            end else begin
              blue_nxt = LvlOff;
            end
          end
          SIG_SUCCESS: begin
            freq_nxt = HZ_1500;
            red_nxt  = LvlOff;
            blue_nxt = LvlOff;
            if (sig_t_r < 7'd20 || (sig_t_r >= 7'd40 && sig_t_r < 7'd60)) begin
              green_nxt = LvlFull;
              buzz_nxt  = 1'b1;
            end else begin
              green_nxt = LvlOff;
              buzz_nxt  = 1'b0;
            end
          end
          default: begin
            buzz_nxt  = 1'b1;
            freq_nxt  = HZ_800;
            green_nxt = LvlOff;
            blue_nxt  = LvlOff;
            if (sig_t_r < 7'd25 || (sig_t_r >= 7'd50 && sig_t_r < 7'd75)) begin
              red_nxt = LvlFull;
            end else begin
              red_nxt = LvlOff;
            end
          end
        endcase
      end
    end else begin
      mode_t_nxt = (bg_t == 8'd255) ? bg_t : bg_t + 8'd1;
      unique case (led_mode_r)
        MODE_NORMAL: begin
          buzz_nxt = 1'b0;
          red_nxt  = LvlOff;
          blue_nxt = LvlOff;
          green_nxt = (bg_t < 8'd100) ? bg_t[LevelW-1:0]
                                      : 7'(8'd200 - bg_t);
        end
        MODE_FLYING: begin
          buzz_nxt  = 1'b0;
          red_nxt   = LvlOff;
          green_nxt = LvlOff;
          if (bg_t < 8'd100) begin
            green_nxt = fly_green;
            blue_nxt  = fly_blue;
          end else if (bg_t < 8'd110 || (bg_t >= 8'd120 && bg_t < 8'd130)) begin
            blue_nxt = LvlFull;
          end else begin
            blue_nxt = LvlOff;
          end
        end
        MODE_PROC1: begin
          buzz_nxt  = 1'b0;
          red_nxt   = LvlOff;
          green_nxt = LvlOff;
          blue_nxt  = {bg_t[5:0], 1'b0};
        end
        MODE_PROC2: begin
          buzz_nxt = 1'b0;
          red_nxt  = LvlOff;
          if (bg_t < 8'd25) begin
            green_nxt = 7'(8'd100 - p2_up);
            blue_nxt  = p2_up[LevelW-1:0];
          end else begin
            green_nxt = p2_dn[LevelW-1:0];
            blue_nxt  = 7'(8'd100 - p2_dn);
          end
        end
        default: begin
          // manual, also for undefined mode codes
          if (man_buz_en_r) freq_nxt = man_hz_r;
          buzz_nxt  = man_buz_en_r;
          red_nxt   = sat100(man_red_r);
          green_nxt = sat100(man_green_r);
          blue_nxt  = sat100(man_blue_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sig_on_r    <= 1'b0;
      sig_id_r    <= '0;
      sig_t_r     <= '0;
      mode_t_r    <= '0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      buzz_r      <= 1'b0;
      freq_r      <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        sig_on_r    <= sig_on_nxt;
        sig_id_r    <= sig_id_nxt;
        sig_t_r     <= sig_t_nxt;
        mode_t_r    <= mode_t_nxt;
        red_r       <= red_nxt;
        green_r     <= green_nxt;
        blue_r      <= blue_nxt;
        buzz_r      <= buzz_nxt;
        freq_r      <= freq_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_level      = red_r;
  assign out_green_level    = green_r;
  assign out_blue_level     = blue_r;
  assign out_buzzer_active  = buzz_r;
  assign out_buzzer_freq_hz = freq_r;
  assign out_signal_playing = sig_on_r;

endmodule
